// ===== src/cfwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfwm_pkg
// shared types, codes and defaults for the circular fifo with minimum query
// ----------------------------------------------------------------------------
`default_nettype none

package cfwm_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 8;

    // field widths
    localparam int DATA_W = 32;
    localparam int OCC_W  = 4;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    // result status codes carried on the output tuser
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_RSVD      = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_en;
        logic load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } t_dp_sts;

endpackage : cfwm_pkg

`default_nettype wire

// ===== src/cfwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfwm_ctrl
// sequencer: takes one transaction, runs the queue update, then the minimum
// scan, and hands the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module cfwm_ctrl
    import cfwm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_done && !i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule : cfwm_ctrl

`default_nettype wire

// ===== src/cfwm_dp.sv =====
// ----------------------------------------------------------------------------
// cfwm_dp
// queue storage, head/tail/count registers, serial minimum scan over the
// held entries and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module cfwm_dp
    import cfwm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [1:0]            i_in_cmd,
    input  wire logic signed [DATA_W-1:0] i_in_value,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic signed [DATA_W-1:0]   o_pop_value,
    output logic [1:0]                 o_status,
    output logic [OCC_W-1:0]           o_occupancy,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic signed [DATA_W-1:0]   o_min_value
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // storage
    logic signed [DATA_W-1:0] r_mem [DEPTH];

    // latched transaction
    logic [1:0]               r_cmd;
    logic signed [DATA_W-1:0] r_value;

    // queue pointers
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // scan and read pipeline
    logic [IDX_W-1:0]         r_scan_idx;
    logic [CNT_W-1:0]         r_scan_cnt;
    logic                     r_rd_vld;
    logic                     r_rd_pop;
    logic                     r_rd_first;
    logic signed [DATA_W-1:0] r_rd_data;

    // result under construction
    logic signed [DATA_W-1:0] r_popped;
    logic signed [DATA_W-1:0] r_min;
    t_status                  r_status;

    // output register
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_pop;
    logic [1:0]               r_out_status;
    logic [OCC_W-1:0]         r_out_occ;
    logic                     r_out_empty;
    logic                     r_out_full;
    logic signed [DATA_W-1:0] r_out_min;

    logic                     w_is_push;
    logic                     w_is_pop;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_do_push;
    logic                     w_do_pop;
    logic                     w_scan_issue;
    logic                     w_rd_en;
    logic [IDX_W-1:0]         w_rd_addr;
    logic [CNT_W+OCC_W-1:0]   w_occ_ext;

    // operation decode
    assign w_is_push = (r_cmd == CMD_PUSH);
    assign w_is_pop  = (r_cmd == CMD_POP);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_do_push = i_cmd.exec && w_is_push && !w_full;
    assign w_do_pop  = i_cmd.exec && w_is_pop && !w_empty;

    // head after a pop, wrapping at the depth
    always_comb begin
        n_head = r_head;
        if (w_do_pop) begin
            n_head = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
    end

    // single read port: pop read during exec, scan reads afterwards
    assign w_scan_issue = i_cmd.scan_en && (r_scan_cnt < r_count);
    assign w_rd_en      = w_do_pop || w_scan_issue;
    assign w_rd_addr    = w_do_pop ? r_head : r_scan_idx;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_tail] <= r_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // latch the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_in_cmd;
            r_value <= i_in_value;
        end
    end

    // queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head <= n_head;
            if (w_do_push) begin
                r_tail  <= (r_tail == IDX_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end else if (w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // scan counters and read tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (i_cmd.exec) begin
                r_scan_cnt <= '0;
            end else if (w_scan_issue) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pop   <= w_do_pop;
        r_rd_first <= (r_scan_cnt == '0);
        if (i_cmd.exec) begin
            r_scan_idx <= n_head;
        end else if (w_scan_issue) begin
            r_scan_idx <= (r_scan_idx == IDX_W'(DEPTH - 1)) ? '0 : r_scan_idx + 1'b1;
        end
    end

    // status code, popped value and running minimum
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_popped <= '0;
            r_min    <= '0;
            if (w_is_push && w_full) begin
                r_status <= STS_OVERFLOW;
            end else if (w_is_pop && w_empty) begin
                r_status <= STS_UNDERFLOW;
            end else begin
                r_status <= STS_OK;
            end
        end else if (r_rd_vld) begin
            if (r_rd_pop) begin
                r_popped <= r_rd_data;
            end else if (r_rd_first || (r_rd_data < r_min)) begin
                r_min <= r_rd_data;
            end
        end
    end

    assign o_sts.scan_done = (r_scan_cnt == r_count) && !r_rd_vld;
    assign o_sts.out_busy  = r_out_vld && !i_m_tready;

    // occupancy keeps its low four bits
    assign w_occ_ext = {{OCC_W{1'b0}}, r_count};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pop    <= r_popped;
            r_out_status <= r_status;
            r_out_occ    <= w_occ_ext[OCC_W-1:0];
            r_out_empty  <= w_empty;
            r_out_full   <= w_full;
            r_out_min    <= r_min;
        end
    end

    assign o_m_tvalid  = r_out_vld;
    assign o_pop_value = r_out_pop;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;
    assign o_is_empty  = r_out_empty;
    assign o_is_full   = r_out_full;
    assign o_min_value = r_out_min;

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    // an accepted push grows the queue by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the queue");

    // an empty queue reports a zero minimum
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && w_empty) |-> (r_min == '0))
        else $error("empty queue with nonzero minimum");

    // a result is only loaded once every scan read has landed
    a_scan_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_rd_vld && (r_scan_cnt == r_count)))
        else $error("result loaded before scan finished");

endmodule : cfwm_dp

`default_nettype wire

// ===== src/circular_fifo_with_min.sv =====
// Sequence: after an input transaction is taken, the exec step runs, then one
// scan read per held value; once the last read has landed, the result is loaded
// and o_m_tvalid rises. The load waits while the output register waits on i_m_tready.
// A new transaction is only taken once the last result is loaded; the minimum
// is a serial memory scan.
// Reset: synchronous active low i_rst_n empties the queue; entries stay unset.
// ----------------------------------------------------------------------------
// circular_fifo_with_min
// circular fifo of signed 32-bit values with push, pop, status read and a
// minimum query over the held values
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_with_min
    import cfwm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] push_value
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [31:0] pop_value, [35:32] occupancy,
                                          // [36] is_empty, [37] is_full,
                                          // [69:38] min_value, [71:70] zero
    output logic [1:0]       o_m_tuser    // [1:0] status
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic signed [DATA_W-1:0] w_pop_value;
    logic [OCC_W-1:0]         w_occupancy;
    logic                     w_is_empty;
    logic                     w_is_full;
    logic signed [DATA_W-1:0] w_min_value;

    // controller
    cfwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    cfwm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_cmd    (i_s_tuser),
        .i_in_value  (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_pop_value (w_pop_value),
        .o_status    (o_m_tuser),
        .o_occupancy (w_occupancy),
        .o_is_empty  (w_is_empty),
        .o_is_full   (w_is_full),
        .o_min_value (w_min_value)
    );

    // pack the result transaction
    assign o_m_tdata = {2'b00, w_min_value, w_is_full, w_is_empty, w_occupancy, w_pop_value};

endmodule : circular_fifo_with_min

`default_nettype wire
